[sv/sv39pti_pkg.sv]
// ----------------------------------------------------------------------------
// sv39pti_pkg: shared types and constants of the Sv39 page table insert unit
// Holds the field widths, pool geometry, entry layout, result codes and the
// controller command and status groups.
// ----------------------------------------------------------------------------
package sv39pti_pkg;

   localparam int POOL_PAGES       = 16;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int PAGE_OFFSET_W    = 12;

   localparam int VA_W     = 39;
   localparam int PA_W     = 56;
   localparam int PPN_W    = 44;
   localparam int LEVEL_W  = 2;
   localparam int STATUS_W = 2;
   localparam int PTE_W    = 64;
   localparam int PAGES_W  = 5;

   localparam int SLOT_W   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int DEPTH    = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int TAKEN_W  = ($clog2(POOL_PAGES + 1) > PAGES_W) ?
                             $clog2(POOL_PAGES + 1) : PAGES_W;

   localparam logic [PPN_W-1:0] POOL_TOP_RESET = PPN_W'(131071);
   localparam logic [9:0]       LEAF_FLAGS     = 10'h0CF;

   localparam logic [LEVEL_W-1:0] LEVEL_4K = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_2M = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_1G = 2'd2;

   // Compact table entry: only the fields that a later walk looks at.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              leaf;
      logic              valid;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [STATUS_W-1:0] {
      ST_MAPPED      = 2'd0,
      ST_ALREADY     = 2'd1,
      ST_EXHAUSTED   = 2'd2,
      ST_LEAF_IN_WAY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       clear_step;
      logic       load_req;
      logic       write_leaf;
      logic       follow;
      logic       take;
      logic       set_status;
      status_type status;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic entry_valid;
      logic entry_leaf;
      logic at_leaf;
      logic pool_full;
      logic out_free;
   } dp_stat_type;

endpackage

[sv/sv39pti_ram.sv]
// ----------------------------------------------------------------------------
// sv39pti_ram: generic single-port RAM
// One write or read address per cycle, read data registered (read first).
// ----------------------------------------------------------------------------
module sv39pti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sv39pti_ctrl.sv]
// ----------------------------------------------------------------------------
// sv39pti_ctrl: walk controller
// Runs the clearing pass after reset, then steps each request through the
// table levels, one read and one evaluation per level.
// ----------------------------------------------------------------------------
module sv39pti_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  sv39pti_pkg::dp_stat_type stat,
   output sv39pti_pkg::dp_cmd_type  cmd
);
   import sv39pti_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_MAPPED;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (stat.at_leaf) begin
               cmd.set_status = 1'b1;
               if (stat.entry_valid) begin
                  cmd.status = ST_ALREADY;
               end else begin
                  cmd.status     = ST_MAPPED;
                  cmd.write_leaf = 1'b1;
               end
            end else if (stat.entry_valid && stat.entry_leaf) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_LEAF_IN_WAY;
            end else if (stat.entry_valid) begin
               cmd.follow = 1'b1;
               state_in   = S_READ;
            end else if (stat.pool_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_EXHAUSTED;
            end else begin
               cmd.take = 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/sv39pti_dpath.sv]
// ----------------------------------------------------------------------------
// sv39pti_dpath: walk datapath
// Holds the request, walk position, page counter, pool register, the table
// memory and the result register.
// ----------------------------------------------------------------------------
module sv39pti_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sv39pti_pkg::VA_W-1:0]        req_va,
   input  logic [sv39pti_pkg::PA_W-1:0]        req_pa,
   input  logic [sv39pti_pkg::LEVEL_W-1:0]     req_level,
   input  logic                                csr_wr_en,
   input  logic [sv39pti_pkg::PPN_W-1:0]       csr_wr_data,
   input  sv39pti_pkg::dp_cmd_type             cmd,
   output sv39pti_pkg::dp_stat_type            stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [sv39pti_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sv39pti_pkg::PTE_W-1:0]       rsp_leaf,
   output logic [sv39pti_pkg::PPN_W-1:0]       rsp_root,
   output logic [sv39pti_pkg::PAGES_W-1:0]     rsp_pages
);
   import sv39pti_pkg::*;

   logic [VA_W-1:0]     va_ff;
   logic [PPN_W-1:0]    ppn_ff;
   logic [LEVEL_W-1:0]  leaf_lvl_ff;
   logic [LEVEL_W-1:0]  level_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [TAKEN_W-1:0]  taken_ff;
   status_type          status_ff;
   logic [PPN_W-1:0]    top_ff;
   logic [ADDR_W-1:0]   clear_addr_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [PTE_W-1:0]    out_leaf_ff;
   logic [PPN_W-1:0]    out_root_ff;
   logic [PAGES_W-1:0]  out_pages_ff;

   logic [IDX_W-1:0]    idx;
   logic [ADDR_W-1:0]   ram_addr;
   logic                ram_wr_en;
   entry_type           ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           entry;
   logic                out_free;

   always_comb begin
      case (level_ff)
         LEVEL_1G: idx = va_ff[PAGE_OFFSET_W + 2*IDX_W +: IDX_W];
         LEVEL_2M: idx = va_ff[PAGE_OFFSET_W + IDX_W +: IDX_W];
         default:  idx = va_ff[PAGE_OFFSET_W +: IDX_W];
      endcase
   end

   assign entry = entry_type'(ram_rdata);

   always_comb begin
      ram_wdata = '0;
      if (cmd.write_leaf) begin
         ram_wdata.valid = 1'b1;
         ram_wdata.leaf  = 1'b1;
      end else if (cmd.take) begin
         ram_wdata.valid = 1'b1;
         ram_wdata.slot  = taken_ff[SLOT_W-1:0];
      end
   end

   assign ram_addr  = cmd.clear_step ? clear_addr_ff : ADDR_W'({slot_ff, idx});
   assign ram_wr_en = cmd.clear_step | cmd.write_leaf | cmd.take;

   sv39pti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff      <= TAKEN_W'(1);
         top_ff        <= POOL_TOP_RESET;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            top_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         end
         if (cmd.take) begin
            taken_ff <= taken_ff + TAKEN_W'(1);
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         va_ff    <= req_va;
         ppn_ff   <= req_pa[PAGE_OFFSET_W +: PPN_W];
         // A level code above the 1GB level walks as a 1GB leaf.
         leaf_lvl_ff <= (req_level > LEVEL_1G) ? LEVEL_1G : req_level;
         level_ff <= LEVEL_1G;
         slot_ff  <= '0;
      end else if (cmd.follow) begin
         level_ff <= level_ff - LEVEL_W'(1);
         slot_ff  <= entry.slot;
      end else if (cmd.take) begin
         level_ff <= level_ff - LEVEL_W'(1);
         slot_ff  <= taken_ff[SLOT_W-1:0];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.publish) begin
         out_status_ff <= status_ff;
         out_leaf_ff   <= (status_ff == ST_MAPPED) ?
                          {(PTE_W - PPN_W - 10)'(0), ppn_ff, LEAF_FLAGS} : '0;
         out_root_ff   <= top_ff - PPN_W'(1);
         out_pages_ff  <= taken_ff[PAGES_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat             = '0;
      stat.clear_done  = (clear_addr_ff == ADDR_W'(DEPTH - 1));
      stat.entry_valid = entry.valid;
      stat.entry_leaf  = entry.leaf;
      stat.at_leaf     = (level_ff == leaf_lvl_ff);
      stat.pool_full   = (taken_ff >= TAKEN_W'(POOL_PAGES));
      stat.out_free    = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_leaf   = out_leaf_ff;
   assign rsp_root   = out_root_ff;
   assign rsp_pages  = out_pages_ff;

endmodule

[sv/sv39_page_table_insert_unit.sv]
// ----------------------------------------------------------------------------
// sv39_page_table_insert_unit: Sv39 page table builder
// Maps one virtual page per request into a three-level table kept in a pool
// of table pages, taking and linking new pages as the walk needs them.
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_tvalid/req_tready  VA, PA, leaf level
//   rsp_      out        rsp_tvalid/rsp_tready  status, leaf PTE, root PPN, pages
//   csr_      in         csr_wr_en              pool top page number
//
// A request is accepted, then each table level from the root down to the leaf level L,
// a code of 3 taken as 2, gets a RAM read and an evaluation, and the result register
// is loaded last. After reset the table RAM is swept to zero, one entry a cycle,
// all POOL_PAGES*512 entries (8192 here), before the first request is taken.
// One request is in flight at a time; a held result stalls the next finish.
// ----------------------------------------------------------------------------
module sv39_page_table_insert_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // virtual_address[38:0], physical_address[94:39], leaf_level[96:95]
   input  logic [103:0]                   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // leaf_entry[63:0], root_page_number[107:64], pages_in_use[112:108]
   output logic [119:0]                   rsp_tdata,
   // status[1:0]
   output logic [1:0]                     rsp_tuser,
   input  logic                           csr_wr_en,
   input  logic [sv39pti_pkg::PPN_W-1:0]  csr_wr_data
);
   import sv39pti_pkg::*;

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic [STATUS_W-1:0] rsp_status;
   logic [PTE_W-1:0]    rsp_leaf;
   logic [PPN_W-1:0]    rsp_root;
   logic [PAGES_W-1:0]  rsp_pages;

   sv39pti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sv39pti_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_va      (req_tdata[VA_W-1:0]),
      .req_pa      (req_tdata[VA_W +: PA_W]),
      .req_level   (req_tdata[VA_W + PA_W +: LEVEL_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_status  (rsp_status),
      .rsp_leaf    (rsp_leaf),
      .rsp_root    (rsp_root),
      .rsp_pages   (rsp_pages)
   );

   assign rsp_tdata = {7'd0, rsp_pages, rsp_root, rsp_leaf};
   assign rsp_tuser = rsp_status;

endmodule
